[src/rps_pkg.sv]
// ----------------------------------------------------------------------------
// rps_pkg
// shared types and constants of the rainbow pixel spi symbol encoder
// ----------------------------------------------------------------------------
package rps_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int SYMS_PER_PIXEL = 24;
    localparam int CNT_W = 5;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [DATA_W-1:0] t_data;
    typedef logic [2:0]        t_pos;
    typedef logic [7:0]        t_level;
    typedef logic [8:0]        t_bright;
    typedef logic [23:0]       t_word;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] REG_HUE_STEP   = 2'd1;
    localparam logic [1:0] REG_VERTICAL   = 2'd2;

    localparam t_bright BRIGHT_RESET = 9'd128;
    localparam t_bright BRIGHT_FULL  = 9'd256;
    localparam t_level  STEP_RESET   = 8'd2;

    localparam t_level SYM_ZERO   = 8'hC0;
    localparam t_level SYM_ONE    = 8'hFC;
    localparam t_level FULL_LEVEL = 8'd255;
    localparam t_level REGION_SPAN = 8'd43;
    localparam logic [3:0] HUE_PER_STEP = 4'd10;

    localparam t_cnt LAST_SYM = t_cnt'(SYMS_PER_PIXEL - 1);

endpackage

[src/rps_if.sv]
// ----------------------------------------------------------------------------
// rps channel interfaces
// valid/ready channels for pixel positions and spi symbols
// ----------------------------------------------------------------------------
interface rps_pix_if;
    logic          valid;
    logic          ready;
    rps_pkg::t_pos column;
    rps_pkg::t_pos row;
    logic          frame_end;

    modport source (output valid, output column, output row, output frame_end, input ready);
    modport sink   (input valid, input column, input row, input frame_end, output ready);
endinterface

interface rps_sym_if;
    logic            valid;
    logic            ready;
    rps_pkg::t_level spi_symbol;
    logic            last_of_pixel;

    modport source (output valid, output spi_symbol, output last_of_pixel, input ready);
    modport sink   (input valid, input spi_symbol, input last_of_pixel, output ready);
endinterface

[src/rps_colour.sv]
// ----------------------------------------------------------------------------
// rps_colour
// six-region hue wheel with brightness scaling, packed green red blue
// ----------------------------------------------------------------------------
module rps_colour (
    input  rps_pkg::t_level  i_hue,
    input  rps_pkg::t_bright i_brightness,
    output rps_pkg::t_word   o_word
);
    import rps_pkg::*;

    logic [2:0] region;
    t_level     base;
    t_level     diff;
    t_level     t_val;
    t_level     q_val;
    t_level     raw_r, raw_g, raw_b;
    logic [16:0] prod_r, prod_g, prod_b;

    always_comb begin
        if (i_hue >= 8'(5 * REGION_SPAN)) begin
            region = 3'd5;
        end else if (i_hue >= 8'(4 * REGION_SPAN)) begin
            region = 3'd4;
        end else if (i_hue >= 8'(3 * REGION_SPAN)) begin
            region = 3'd3;
        end else if (i_hue >= 8'(2 * REGION_SPAN)) begin
            region = 3'd2;
        end else if (i_hue >= REGION_SPAN) begin
            region = 3'd1;
        end else begin
            region = 3'd0;
        end
    end

    always_comb begin
        case (region)
            3'd0:    base = 8'd0;
            3'd1:    base = REGION_SPAN;
            3'd2:    base = 8'(2 * REGION_SPAN);
            3'd3:    base = 8'(3 * REGION_SPAN);
            3'd4:    base = 8'(4 * REGION_SPAN);
            default: base = 8'(5 * REGION_SPAN);
        endcase
    end

    assign diff  = i_hue - base;
    assign t_val = 8'({diff, 2'b00} + {diff, 1'b0});
    assign q_val = FULL_LEVEL - t_val;

    always_comb begin
        case (region)
            3'd0: begin
                raw_r = FULL_LEVEL; raw_g = t_val;      raw_b = 8'd0;
            end
            3'd1: begin
                raw_r = q_val;      raw_g = FULL_LEVEL; raw_b = 8'd0;
            end
            3'd2: begin
                raw_r = 8'd0;       raw_g = FULL_LEVEL; raw_b = t_val;
            end
            3'd3: begin
                raw_r = 8'd0;       raw_g = q_val;      raw_b = FULL_LEVEL;
            end
            3'd4: begin
                raw_r = t_val;      raw_g = 8'd0;       raw_b = FULL_LEVEL;
            end
            default: begin
                raw_r = FULL_LEVEL; raw_g = 8'd0;       raw_b = q_val;
            end
        endcase
    end

    assign prod_r = {9'd0, raw_r} * {8'd0, i_brightness};
    assign prod_g = {9'd0, raw_g} * {8'd0, i_brightness};
    assign prod_b = {9'd0, raw_b} * {8'd0, i_brightness};

    assign o_word = {prod_g[15:8], prod_r[15:8], prod_b[15:8]};

endmodule

[src/rainbow_pixel_spi_symbol_encoder.sv]
// ----------------------------------------------------------------------------
// rainbow_pixel_spi_symbol_encoder
// pixel position to rainbow colour, sent as 24 spi symbol bytes per pixel
// ----------------------------------------------------------------------------
// channel  dir  beat payload
// i_pix    in   column, row, frame_end
// o_sym    out  spi_symbol, last_of_pixel
// apb      in   brightness @0x0, hue_step_per_frame @0x4, vertical_mode @0x8
//
// each pixel is 24 symbol beats, one beat per cycle from the serializer while o_sym.ready is high
// pipeline: hue register, colour word register, then the shift register
// a new pixel is taken while the previous one is still being shifted out
// output stalls hold the serializer and back-pressure the two stages ahead
// synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
module rainbow_pixel_spi_symbol_encoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rps_pix_if.sink         i_pix,
    rps_sym_if.source       o_sym,
    input  logic            i_psel,
    input  logic            i_penable,
    input  logic            i_pwrite,
    input  rps_pkg::t_addr  i_paddr,
    input  rps_pkg::t_data  i_pwdata,
    output rps_pkg::t_data  o_prdata,
    output logic            o_pready
);
    import rps_pkg::*;

    t_bright r_brightness;
    t_level  r_step;
    logic    r_vertical;
    t_level  r_hue_base;

    logic    r_hue_vld;
    t_level  r_hue;
    logic    r_word_vld;
    t_word   r_word;
    logic    r_busy;
    t_word   r_shift;
    t_cnt    r_cnt;

    logic    cfg_wr;
    logic [1:0] cfg_idx;
    t_bright wr_bright;
    t_pos    pos;
    logic [6:0] pos_x10;
    t_level  n_hue;
    t_word   colour_word;
    logic    in_beat;
    logic    out_beat;
    logic    out_last;
    logic    load;
    logic    word_ready;

    // configuration port
    assign o_pready = 1'b1;
    assign cfg_idx  = i_paddr[3:2];
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign wr_bright = (i_pwdata[8:0] > BRIGHT_FULL) ? BRIGHT_FULL : i_pwdata[8:0];

    always_comb begin
        case (cfg_idx)
            REG_BRIGHTNESS: o_prdata = {23'd0, r_brightness};
            REG_HUE_STEP:   o_prdata = {24'd0, r_step};
            REG_VERTICAL:   o_prdata = {31'd0, r_vertical};
            default:        o_prdata = '0;
        endcase
    end

    // handshakes
    assign out_last   = (r_cnt == LAST_SYM);
    assign out_beat   = o_sym.valid && o_sym.ready;
    assign load       = r_word_vld && (!r_busy || (out_beat && out_last));
    assign word_ready = !r_word_vld || load;
    assign i_pix.ready = !r_hue_vld || word_ready;
    assign in_beat    = i_pix.valid && i_pix.ready;

    // hue from position
    assign pos     = r_vertical ? i_pix.row : i_pix.column;
    assign pos_x10 = {1'b0, pos, 3'b000} + {3'b000, pos, 1'b0};
    assign n_hue   = r_hue_base + {1'b0, pos_x10};

    rps_colour u_colour (
        .i_hue        (r_hue),
        .i_brightness (r_brightness),
        .o_word       (colour_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= BRIGHT_RESET;
            r_step       <= STEP_RESET;
            r_vertical   <= 1'b0;
            r_hue_base   <= '0;
            r_hue_vld    <= 1'b0;
            r_word_vld   <= 1'b0;
            r_busy       <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_BRIGHTNESS: r_brightness <= wr_bright;
                    REG_HUE_STEP:   r_step       <= i_pwdata[7:0];
                    REG_VERTICAL:   r_vertical   <= i_pwdata[0];
                    default: begin
                    end
                endcase
            end
            if (in_beat && i_pix.frame_end) begin
                r_hue_base <= r_hue_base + r_step;
            end
            if (i_pix.ready) begin
                r_hue_vld <= i_pix.valid;
            end
            if (word_ready) begin
                r_word_vld <= r_hue_vld;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (out_beat) begin
                if (out_last) begin
                    r_busy <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_hue <= n_hue;
        end
        if (word_ready && r_hue_vld) begin
            r_word <= colour_word;
        end
        if (load) begin
            r_shift <= r_word;
        end else if (out_beat) begin
            r_shift <= {r_shift[22:0], 1'b0};
        end
    end

    assign o_sym.valid         = r_busy;
    assign o_sym.spi_symbol    = r_shift[23] ? SYM_ONE : SYM_ZERO;
    assign o_sym.last_of_pixel = out_last;

    // checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= LAST_SYM))
        else $error("symbol count out of range");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && !out_last) |=> (r_cnt == $past(r_cnt) + 1'b1) && r_busy)
        else $error("symbol count did not advance");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && out_last && !r_word_vld) |=> !r_busy)
        else $error("serializer busy after last beat with nothing pending");

    a_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && i_pix.frame_end) |=> (r_hue_base == $past(r_hue_base + r_step)))
        else $error("hue base not advanced at frame end");

    a_offset_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_beat && i_pix.frame_end) |=> $stable(r_hue_base))
        else $error("hue base moved without frame end");

endmodule

[verif/rps_symbol_checker.sv]
// ----------------------------------------------------------------------------
// rps_symbol_checker
// watches the pixel, symbol and register ports of the rainbow encoder, works
// out the 24 symbol beats each accepted pixel must produce and compares every
// symbol beat with the oldest one still due
// ----------------------------------------------------------------------------
module rps_symbol_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rps_pix_if             i_pix,
    rps_sym_if             i_sym,
    input  logic           i_psel,
    input  logic           i_penable,
    input  logic           i_pwrite,
    input  rps_pkg::t_addr i_paddr,
    input  rps_pkg::t_data i_pwdata,
    input  logic           i_pready,
    output int             o_fail_count,
    output int             o_pending
);
    import rps_pkg::*;

    localparam int REGION_GAIN = 6;

    typedef struct packed {
        t_level symbol;
        logic   last;
    } t_symbol_beat;

    t_symbol_beat expected_symbols[$];
    t_bright      brightness;
    t_level       hue_step;
    logic         vertical;
    t_level       hue_base;
    int           mismatches = 0;
    int           symbols_due = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = symbols_due;

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic t_level dim_level(input int raw, input t_bright gain);
        return t_level'((raw * int'(gain)) >> 8);
    endfunction

    task automatic encode_pixel(input t_pos col, input t_pos row, input logic frame_end);
        int           pos;
        int           hue;
        int           region;
        int           ramp;
        int           fall;
        int           red;
        int           green;
        int           blue;
        t_word        grb;
        t_symbol_beat beat;
        pos    = vertical ? int'(row) : int'(col);
        hue    = (int'(hue_base) + pos * int'(HUE_PER_STEP)) & 8'hFF;
        region = hue / int'(REGION_SPAN);
        ramp   = (hue - region * int'(REGION_SPAN)) * REGION_GAIN;
        fall   = int'(FULL_LEVEL) - ramp;
        case (region)
            0: begin
                red = FULL_LEVEL; green = ramp;       blue = 0;
            end
            1: begin
                red = fall;       green = FULL_LEVEL; blue = 0;
            end
            2: begin
                red = 0;          green = FULL_LEVEL; blue = ramp;
            end
            3: begin
                red = 0;          green = fall;       blue = FULL_LEVEL;
            end
            4: begin
                red = ramp;       green = 0;          blue = FULL_LEVEL;
            end
            default: begin
                red = FULL_LEVEL; green = 0;          blue = fall;
            end
        endcase
        grb = {dim_level(green, brightness), dim_level(red, brightness),
               dim_level(blue, brightness)};
        for (int k = 0; k < SYMS_PER_PIXEL; k++) begin
            beat.symbol = grb[SYMS_PER_PIXEL-1-k] ? SYM_ONE : SYM_ZERO;
            beat.last   = (k == SYMS_PER_PIXEL - 1);
            expected_symbols.push_back(beat);
        end
        if (frame_end) begin
            hue_base = hue_base + hue_step;
        end
    endtask

    always @(posedge i_clk) begin : watch
        int           added;
        int           taken;
        t_bright      bright_wr;
        t_symbol_beat due;
        added = 0;
        taken = 0;
        if (!i_rst_n) begin
            brightness = BRIGHT_RESET;
            hue_step   = STEP_RESET;
            vertical   = 1'b0;
            hue_base   = '0;
            expected_symbols.delete();
            symbols_due <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_BRIGHTNESS: begin
                        bright_wr  = i_pwdata[8:0];
                        brightness = (bright_wr > BRIGHT_FULL) ? BRIGHT_FULL : bright_wr;
                    end
                    REG_HUE_STEP: hue_step = i_pwdata[7:0];
                    REG_VERTICAL: vertical = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_sym.valid && i_sym.ready) begin
                if (expected_symbols.size() == 0) begin
                    report_mismatch($sformatf("symbol beat %h/%b with none due",
                                              i_sym.spi_symbol, i_sym.last_of_pixel));
                end else begin
                    due   = expected_symbols.pop_front();
                    taken = 1;
                    if (i_sym.spi_symbol !== due.symbol) begin
                        report_mismatch($sformatf("spi_symbol %h, due %h",
                                                  i_sym.spi_symbol, due.symbol));
                    end
                    if (i_sym.last_of_pixel !== due.last) begin
                        report_mismatch($sformatf("last_of_pixel %b, due %b",
                                                  i_sym.last_of_pixel, due.last));
                    end
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                encode_pixel(i_pix.column, i_pix.row, i_pix.frame_end);
                added = SYMS_PER_PIXEL;
            end
            symbols_due <= symbols_due + added - taken;
        end
    end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// drives pixel positions and register writes into the rainbow encoder under
// random sender and receiver idling; a directed opening walks the register
// extremes and the last hue region, then random pixels run under several
// register settings while the checker predicts every symbol beat
// ----------------------------------------------------------------------------
module tb;
    import rps_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int SEGMENTS     = 8;
    localparam int SEG_PIXELS   = 50;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   pix_valid = 1'b0;
    t_pos   pix_column = '0;
    t_pos   pix_row = '0;
    logic   pix_frame_end = 1'b0;
    logic   sym_ready = 1'b0;
    logic   psel = 1'b0;
    logic   penable = 1'b0;
    logic   pwrite = 1'b0;
    t_addr  paddr = '0;
    t_data  pwdata = '0;
    t_data  prdata;
    logic   pready;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     cycles = 0;
    int     fail_count;
    int     pending;

    rps_pix_if pix_ch();
    rps_sym_if sym_ch();

    assign pix_ch.valid     = pix_valid;
    assign pix_ch.column    = pix_column;
    assign pix_ch.row       = pix_row;
    assign pix_ch.frame_end = pix_frame_end;
    assign sym_ch.ready     = sym_ready;

    rainbow_pixel_spi_symbol_encoder dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (pix_ch),
        .o_sym     (sym_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    rps_symbol_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_ch),
        .i_sym        (sym_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        sym_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL rainbow_pixel_spi_symbol_encoder");
            $finish;
        end
    end

    task automatic send_pixel(input t_pos col, input t_pos row, input logic frame_end);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pix_valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_valid     <= 1'b1;
        pix_column    <= col;
        pix_row       <= row;
        pix_frame_end <= frame_end;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        pix_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] index, input t_data value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= t_addr'({index, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic pick_settings();
        t_data bright_wr;
        bright_wr = $urandom();
        case ($urandom_range(0, 5))
            0: bright_wr[8:0] = 9'd0;
            1: bright_wr[8:0] = BRIGHT_FULL;
            2: bright_wr[8:0] = 9'h1FF;
            3: bright_wr[8:0] = 9'd1;
            default: bright_wr[8:0] = 9'($urandom_range(0, 511));
        endcase
        reg_write(REG_BRIGHTNESS, bright_wr);
        reg_write(REG_HUE_STEP, $urandom());
        reg_write(REG_VERTICAL, $urandom());
    endtask

    initial begin
        send_idle_pct = 27;
        recv_idle_pct = 88;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings
        send_pixel(3'd0, 3'd0, 1'b0);
        send_pixel(3'd7, 3'd7, 1'b0);
        send_pixel(3'd3, 3'd5, 1'b1);
        wait_drained();

        // full scale, big step lands the offset in the last hue region
        reg_write(REG_BRIGHTNESS, 32'h0000_0100);
        reg_write(REG_HUE_STEP, 32'hFFFF_FFD7);
        reg_write(REG_VERTICAL, 32'h0000_0000);
        reg_write(REG_UNUSED, $urandom());
        send_pixel(3'd0, 3'd0, 1'b1);
        send_pixel(3'd0, 3'd3, 1'b0);
        send_pixel(3'd3, 3'd0, 1'b0);
        send_pixel(3'd4, 3'd7, 1'b0);
        send_pixel(3'd7, 3'd0, 1'b1);
        wait_drained();

        // brightness above full, row mode, no hue advance
        reg_write(REG_BRIGHTNESS, 32'h0000_01FF);
        reg_write(REG_VERTICAL, 32'hFFFF_FFFF);
        reg_write(REG_HUE_STEP, 32'h0000_0000);
        send_pixel(3'd5, 3'd0, 1'b0);
        send_pixel(3'd2, 3'd7, 1'b1);
        send_pixel(3'd7, 3'd4, 1'b0);
        wait_drained();

        // dark, maximum step
        reg_write(REG_BRIGHTNESS, 32'h0000_0000);
        reg_write(REG_HUE_STEP, 32'h0000_00FF);
        reg_write(REG_VERTICAL, 32'h0000_0002);
        send_pixel(3'd7, 3'd0, 1'b1);
        send_pixel(3'd0, 3'd7, 1'b1);
        send_pixel(3'd1, 3'd1, 1'b0);
        wait_drained();

        reg_write(REG_BRIGHTNESS, 32'h0000_0101);
        reg_write(REG_HUE_STEP, 32'h0000_002B);
        send_pixel(3'd6, 3'd2, 1'b1);
        send_pixel(3'd1, 3'd6, 1'b0);
        send_pixel(3'd7, 3'd7, 1'b1);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_drained();
            if (seg < 3) begin
                send_idle_pct = 27;
                recv_idle_pct = 88;
            end else if (seg < 6) begin
                send_idle_pct = 88;
                recv_idle_pct = 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick_settings();
            for (int n = 0; n < SEG_PIXELS; n++) begin
                if ($urandom_range(0, 39) == 0) begin
                    wait_drained();
                end
                send_pixel(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                           ($urandom_range(0, 5) == 0));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS rainbow_pixel_spi_symbol_encoder");
        end else begin
            $display("FAIL rainbow_pixel_spi_symbol_encoder");
        end
        $finish;
    end

endmodule
